[design/sliding_window_percentile_monitor_core_macros.svh]
// assertion macros for the sliding window percentile monitor checker
// expects clk_i and rst_ni in the scope of use
`ifndef SLIDING_WINDOW_PERCENTILE_MONITOR_CORE_MACROS_SVH
`define SLIDING_WINDOW_PERCENTILE_MONITOR_CORE_MACROS_SVH

// same-cycle implication
`define SWPM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swpm check failed");

// next-cycle implication
`define SWPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swpm check failed");

`endif

[design/swpm_pkg.sv]
// shared types and constants for the sliding window percentile monitor
// no dependencies
`default_nettype none

package swpm_pkg;

  localparam int DATA_W    = 24;
  localparam int SAMPLE_W  = 25;
  localparam int CNT_OUT_W = 11;
  localparam int REJ_W     = 32;
  localparam int ADDR_W    = 3;
  localparam int PDATA_W   = 32;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_BUDGET = 3'd0;

  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] val;
  } swpm_item_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } swpm_cell_ctrl_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FEED  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_READ  = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_SPARE = 6'b100000
  } swpm_state_e;

endpackage

`default_nettype wire

[design/sliding_window_percentile_monitor_core.sv]
// top level of the sliding window percentile monitor: ring memory, sorting chain, control
// depends on swpm_pkg, swpm_cell, swpm_div
//
//  channel   | handshake                 | carries
//  ----------+---------------------------+----------------------------------------
//  in        | in_valid_i / in_ready_o   | action_i, sample_i, sample_bad_i
//  out       | out_valid_o / out_ready_i | sample_count_o .. rejected_count_o
//  config    | psel/penable/pwrite       | budget at byte address 0
//
// push, clear and unused actions complete in the idle state; an empty query goes straight to ST_FIN
// a query with samples steps through ST_FEED (feed), ST_DRAIN (chain settling), ST_READ
//   (readout overlapped with the mean divider) and ST_FIN (load the result register)
// reset clears pointers, counts, budget and the chain; the ring needs no clearing
// a finished result waits in the output register; the next request is taken meanwhile,
//   but a later query cannot hand over its result until the earlier one is taken
`default_nettype none

module sliding_window_percentile_monitor_core #(
  parameter int WINDOW = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic signed [swpm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                sample_bad_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [swpm_pkg::CNT_OUT_W-1:0]      sample_count_o,
  output logic [swpm_pkg::DATA_W-1:0]         min_time_o,
  output logic [swpm_pkg::DATA_W-1:0]         max_time_o,
  output logic [swpm_pkg::DATA_W-1:0]         mean_time_o,
  output logic [swpm_pkg::DATA_W-1:0]         median_time_o,
  output logic [swpm_pkg::DATA_W-1:0]         p95_time_o,
  output logic [swpm_pkg::DATA_W-1:0]         p99_time_o,
  output logic [swpm_pkg::CNT_OUT_W-1:0]      over_budget_count_o,
  output logic [swpm_pkg::REJ_W-1:0]          rejected_count_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swpm_pkg::ADDR_W-1:0]         paddr,
  input  logic [swpm_pkg::PDATA_W-1:0]        pwdata,
  output logic [swpm_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import swpm_pkg::*;

  localparam int AW    = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int RK_W  = CNT_W + 7;

  // ---------------- handshake decode
  swpm_state_e state_q, state_d;
  logic        acc_in, push_ok, push_rej, do_clear, do_query;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc_in     = in_valid_i && in_ready_o;
  assign push_ok    = acc_in && (action_i == ACT_PUSH) && !sample_bad_i
                      && !sample_i[SAMPLE_W-1];
  assign push_rej   = acc_in && (action_i == ACT_PUSH) && !push_ok;
  assign do_clear   = acc_in && (action_i == ACT_CLEAR);
  assign do_query   = acc_in && (action_i == ACT_QUERY);

  // ---------------- configuration
  logic [DATA_W-1:0] budget_q;
  logic              cfg_sel, cfg_wr;

  // word decode, byte lanes ignored
  assign cfg_sel = (paddr[ADDR_W-1:2] == ADDR_BUDGET[ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? {{(PDATA_W-DATA_W){1'b0}}, budget_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (cfg_wr) begin
      budget_q <= pwdata[DATA_W-1:0];
    end
  end

  // ---------------- window bookkeeping
  logic [AW-1:0]    wp_q;
  logic [CNT_W-1:0] fill_q;
  logic [REJ_W-1:0] rej_q;
  logic             full;

  assign full = (fill_q == CNT_W'(WINDOW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      rej_q  <= '0;
    end else if (do_clear) begin
      wp_q   <= '0;
      fill_q <= '0;
      rej_q  <= '0;
    end else if (push_rej) begin
      rej_q <= rej_q + 1'b1;
    end else if (push_ok) begin
      wp_q <= (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
      if (!full) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // ---------------- ring memory, registered read
  logic [DATA_W-1:0] ring_mem [WINDOW];
  logic [DATA_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      ring_mem[wp_q] <= sample_i[DATA_W-1:0];
    end
    rd_data_q <= ring_mem[rd_ptr_q];
  end

  // ---------------- query sequencer
  logic [CNT_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] over_q;
  logic [RK_W-1:0]  thr50_q, thr95_q, thr99_q, rank_q;
  logic             got50_q, got95_q, got99_q;
  logic [DATA_W-1:0] min_q, max_q, p50_q, p95_q, p99_q;
  logic             last_feed, drain_done, last_read, div_start, div_done, out_free;
  logic [SUM_W-1:0] quo;
  swpm_item_t       head;

  assign last_feed  = (cnt_q == fill_q - 1'b1);
  assign drain_done = (cnt_q == fill_q);
  assign last_read  = (cnt_q == fill_q - 1'b1);
  assign div_start  = (state_q == ST_DRAIN) && drain_done;
  assign out_free   = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_query) begin
          state_d = (fill_q == '0) ? ST_FIN : ST_FEED;
        end
      end
      ST_FEED:  if (last_feed) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_done) state_d = ST_READ;
      ST_READ:  if (last_read) state_d = ST_FIN;
      ST_FIN: begin
        if (out_free && (div_done || fill_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_ptr_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_FEED);
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
      // oldest entry first: the write pointer once the ring has wrapped
      if (do_query) begin
        rd_ptr_q <= full ? wp_q : '0;
      end else if (state_q == ST_FEED) begin
        rd_ptr_q <= (rd_ptr_q == AW'(WINDOW - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // running sum and over-budget count while samples stream in
  // percentile ranks: sample k+1 is taken once 100*(k+1) >= q*n
  always_ff @(posedge clk_i) begin
    if (do_query) begin
      sum_q   <= '0;
      over_q  <= '0;
      thr50_q <= RK_W'(fill_q) * RK_W'(50);
      thr95_q <= RK_W'(fill_q) * RK_W'(95);
      thr99_q <= RK_W'(fill_q) * RK_W'(99);
      rank_q  <= RK_W'(100);
      got50_q <= 1'b0;
      got95_q <= 1'b0;
      got99_q <= 1'b0;
      min_q   <= '0;
      max_q   <= '0;
      p50_q   <= '0;
      p95_q   <= '0;
      p99_q   <= '0;
    end else begin
      if (rd_vld_q) begin
        sum_q <= sum_q + SUM_W'(rd_data_q);
        if ((budget_q != '0) && (rd_data_q > budget_q)) begin
          over_q <= over_q + 1'b1;
        end
      end
      if (state_q == ST_READ) begin
        rank_q <= rank_q + RK_W'(100);
        if (cnt_q == '0) begin
          min_q <= head.val;
        end
        if (last_read) begin
          max_q <= head.val;
        end
        if (!got50_q && rank_q >= thr50_q) begin
          got50_q <= 1'b1;
          p50_q   <= head.val;
        end
        if (!got95_q && rank_q >= thr95_q) begin
          got95_q <= 1'b1;
          p95_q   <= head.val;
        end
        if (!got99_q && rank_q >= thr99_q) begin
          got99_q <= 1'b1;
          p99_q   <= head.val;
        end
      end
    end
  end

  // ---------------- sorting chain: ascending from cell 0
  swpm_cell_ctrl_t ctrl;
  swpm_item_t      cell_in   [WINDOW];
  swpm_item_t      cell_rt   [WINDOW];
  swpm_item_t      cell_held [WINDOW];
  swpm_item_t      cell_pass [WINDOW];

  assign ctrl.clr   = do_query;
  assign ctrl.shift = (state_q == ST_READ);
  assign head       = cell_held[0];

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cell_in[k] = '{vld: rd_vld_q, val: rd_data_q};
    end else begin : g_mid
      assign cell_in[k] = cell_pass[k-1];
    end
    if (k == WINDOW - 1) begin : g_last
      assign cell_rt[k] = '0;
    end else begin : g_inner
      assign cell_rt[k] = cell_held[k+1];
    end
    swpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .in_i    (cell_in[k]),
      .right_i (cell_rt[k]),
      .held_o  (cell_held[k]),
      .pass_o  (cell_pass[k])
    );
  end

  // ---------------- mean
  swpm_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (fill_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // ---------------- output register
  logic                          out_valid_q;
  logic [CNT_W+CNT_OUT_W-1:0]    n_ext, over_ext;
  logic                          fin_load;

  assign fin_load = (state_q == ST_FIN) && (state_d == ST_IDLE);
  assign n_ext    = {{CNT_OUT_W{1'b0}}, fill_q};
  assign over_ext = {{CNT_OUT_W{1'b0}}, over_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      rejected_count_o <= rej_q;
      if (fill_q == '0) begin
        sample_count_o      <= '0;
        min_time_o          <= '0;
        max_time_o          <= '0;
        mean_time_o         <= '0;
        median_time_o       <= '0;
        p95_time_o          <= '0;
        p99_time_o          <= '0;
        over_budget_count_o <= '0;
      end else begin
        sample_count_o      <= n_ext[CNT_OUT_W-1:0];
        min_time_o          <= min_q;
        max_time_o          <= max_q;
        mean_time_o         <= quo[DATA_W-1:0];
        median_time_o       <= p50_q;
        p95_time_o          <= p95_q;
        p99_time_o          <= p99_q;
        over_budget_count_o <= over_ext[CNT_OUT_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[design/swpm_cell.sv]
// one sorting cell of the insertion chain: keeps one sample, passes the larger on
// depends on swpm_pkg
`default_nettype none

module swpm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  swpm_pkg::swpm_cell_ctrl_t ctrl_i,
  input  swpm_pkg::swpm_item_t      in_i,
  input  swpm_pkg::swpm_item_t      right_i,
  output swpm_pkg::swpm_item_t      held_o,
  output swpm_pkg::swpm_item_t      pass_o
);
  import swpm_pkg::*;

  swpm_item_t held_q, held_d, pass_q, pass_d;

  always_comb begin
    held_d     = held_q;
    pass_d     = pass_q;
    pass_d.vld = 1'b0;
    if (ctrl_i.clr) begin
      held_d.vld = 1'b0;
    end else if (ctrl_i.shift) begin
      held_d = right_i;
    end else if (in_i.vld) begin
      if (!held_q.vld) begin
        held_d = in_i;
      end else if (in_i.val < held_q.val) begin
        held_d = in_i;
        pass_d = held_q;
      end else begin
        pass_d = in_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign held_o = held_q;
  assign pass_o = pass_q;

endmodule

`default_nettype wire

[design/swpm_div.sv]
// restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none

module swpm_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem_q, rem_d, rem_sh;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;

  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = !busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

[design/swpm_chk.sv]
// port-level checker for the sliding window percentile monitor, bound to the top level
// depends on swpm_pkg and the macros header
`default_nettype none
`include "sliding_window_percentile_monitor_core_macros.svh"

module swpm_chk #(
  parameter int WINDOW = 1024
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [1:0]                         action_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [swpm_pkg::CNT_OUT_W-1:0]     sample_count_o,
  input logic [swpm_pkg::CNT_OUT_W-1:0]     over_budget_count_o
);
  import swpm_pkg::*;

  localparam logic [CNT_OUT_W+20:0] WIN = (CNT_OUT_W+21)'(WINDOW);

  logic [CNT_OUT_W+20:0] cnt_ext;
  assign cnt_ext = {21'b0, sample_count_o};

  `SWPM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `SWPM_ASSERT_NOW(a_over_le_cnt, out_valid_o, over_budget_count_o <= sample_count_o)
  `SWPM_ASSERT_NOW(a_cnt_le_win, out_valid_o, cnt_ext <= WIN)
  `SWPM_ASSERT_NEXT(a_query_busy, in_valid_i && in_ready_o && action_i == ACT_QUERY, !in_ready_o)

endmodule

bind sliding_window_percentile_monitor_core swpm_chk #(.WINDOW(WINDOW)) u_swpm_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .action_i            (action_i),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .sample_count_o      (sample_count_o),
  .over_budget_count_o (over_budget_count_o)
);

`default_nettype wire
